// ===== rtl/bnc_pkg.sv =====
// Shared types, codes and the bracket decoder of the bracket nesting checker.
`timescale 1ns / 1ps
package bnc_pkg;

  typedef logic [1:0] bnc_kind_t;

  localparam bnc_kind_t KIND_ROUND  = 2'd0;
  localparam bnc_kind_t KIND_SQUARE = 2'd1;
  localparam bnc_kind_t KIND_CURLY  = 2'd2;
  localparam bnc_kind_t KIND_ANGLE  = 2'd3;

  localparam logic [1:0] STATUS_BALANCED   = 2'd0;
  localparam logic [1:0] STATUS_INCOMPLETE = 2'd1;
  localparam logic [1:0] STATUS_CORRUPTED  = 2'd2;
  localparam logic [1:0] STATUS_OVERFLOW   = 2'd3;

  localparam logic [2:0] REG_ERR_ROUND  = 3'd0;
  localparam logic [2:0] REG_ERR_SQUARE = 3'd1;
  localparam logic [2:0] REG_ERR_CURLY  = 3'd2;
  localparam logic [2:0] REG_ERR_ANGLE  = 3'd3;
  localparam logic [2:0] REG_PNT_ROUND  = 3'd4;
  localparam logic [2:0] REG_PNT_SQUARE = 3'd5;
  localparam logic [2:0] REG_PNT_CURLY  = 3'd6;
  localparam logic [2:0] REG_PNT_ANGLE  = 3'd7;

  localparam int SCORE_W  = 16;
  localparam int POINT_W  = 4;
  localparam int TOTAL_W  = 32;
  localparam int COMP_W   = 64;

  // Shift control for the row of stack cells
  typedef struct packed {
    logic push;
    logic pop;
  } bnc_shift_t;

  typedef struct packed {
    logic      is_open;
    logic      is_close;
    bnc_kind_t kind;
  } bnc_class_t;

  function automatic bnc_class_t bnc_classify(input logic [7:0] c);
    bnc_class_t r;
    r = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
    case (c)
      8'h28: r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ROUND};
      8'h5B: r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_SQUARE};
      8'h7B: r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_CURLY};
      8'h3C: r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ANGLE};
      8'h29: r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ROUND};
      8'h5D: r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_SQUARE};
      8'h7D: r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_CURLY};
      8'h3E: r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ANGLE};
      default: r = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/bnc_cell.sv =====
// One stack cell: holds a bracket kind and shifts with its neighbors on push or pop.
`timescale 1ns / 1ps
module bnc_cell
  import bnc_pkg::*;
(
  input  logic       clk_i,
  input  bnc_shift_t ctrl_i,
  input  bnc_kind_t  up_kind_i,
  input  bnc_kind_t  down_kind_i,
  output bnc_kind_t  kind_o
);

  bnc_kind_t kind_q;

  // push takes the entry from above, pop takes the one from below
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      kind_q <= up_kind_i;
    end else if (ctrl_i.pop) begin
      kind_q <= down_kind_i;
    end
  end

  assign kind_o = kind_q;

endmodule

// ===== rtl/bnc_completion.sv =====
// Completion score accumulator: score times five plus a digit, saturating.
`timescale 1ns / 1ps
module bnc_completion
  import bnc_pkg::*;
(
  input  logic               clk_i,
  input  logic               clear_i,
  input  logic               step_i,
  input  logic [POINT_W-1:0] digit_i,
  output logic [COMP_W-1:0]  score_o
);

  logic [COMP_W-1:0] score_q, score_d;
  logic [COMP_W+2:0] wide;

  always_comb begin
    wide = {3'b000, score_q} + {1'b0, score_q, 2'b00} + (COMP_W+3)'(digit_i);
    if (wide[COMP_W+2:COMP_W] != 3'b000) begin
      score_d = '1;
    end else begin
      score_d = wide[COMP_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear_i) begin
      score_q <= '0;
    end else if (step_i) begin
      score_q <= score_d;
    end
  end

  assign score_o = score_q;

endmodule

// ===== rtl/bracket_nesting_checker.sv =====
// Balanced, corrupted or overflowed line results are registered in the cycle
// after their end-of-line item. An incomplete line with L open brackets unwinds:
// L pops into the completion accumulator, then the result loads. Throughput is
// one item per cycle outside unwind; end-of-line items also wait for free output.
// Reset clears control, counters and the error total and loads register
// defaults; stack cell contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
module bracket_nesting_checker
  import bnc_pkg::*;
#(
  parameter int STACK_DEPTH = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [SCORE_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_op_i,
  input  logic [7:0]         in_char_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         out_line_status_o,
  output logic [SCORE_W-1:0] out_line_error_score_o,
  output logic [TOTAL_W-1:0] out_total_error_score_o,
  output logic [COMP_W-1:0]  out_completion_score_o
);

  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam logic S_RUN    = 1'b0;
  localparam logic S_UNWIND = 1'b1;

  logic [SCORE_W-1:0] err_score_q [4];
  logic [POINT_W-1:0] point_q [4];

  logic               state_q, state_d;
  logic [LVL_W-1:0]   level_q, level_d;
  logic               corrupted_q, corrupted_d;
  logic               overflowed_q, overflowed_d;
  logic [SCORE_W-1:0] latched_q, latched_d;
  logic [TOTAL_W-1:0] total_q, total_d;

  logic               out_valid_q;
  logic [1:0]         status_q;
  logic [SCORE_W-1:0] line_err_q;
  logic [TOTAL_W-1:0] line_total_q;
  logic [COMP_W-1:0]  comp_out_q;

  bnc_class_t         cls;
  bnc_shift_t         shift;
  bnc_kind_t          kinds [STACK_DEPTH];
  logic               accept, out_free, active, char_acc, eol_acc;
  logic               top_match, do_corrupt, out_load;
  logic [1:0]         out_status;
  logic [SCORE_W-1:0] out_err;
  logic [COMP_W-1:0]  comp;
  logic [TOTAL_W:0]   total_sum;
  logic               comp_clear;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_score_q[KIND_ROUND]  <= 16'd3;
      err_score_q[KIND_SQUARE] <= 16'd57;
      err_score_q[KIND_CURLY]  <= 16'd1197;
      err_score_q[KIND_ANGLE]  <= 16'd25137;
      point_q[KIND_ROUND]      <= 4'd1;
      point_q[KIND_SQUARE]     <= 4'd2;
      point_q[KIND_CURLY]      <= 4'd3;
      point_q[KIND_ANGLE]      <= 4'd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ERR_ROUND:  err_score_q[KIND_ROUND]  <= cfg_wdata_i;
        REG_ERR_SQUARE: err_score_q[KIND_SQUARE] <= cfg_wdata_i;
        REG_ERR_CURLY:  err_score_q[KIND_CURLY]  <= cfg_wdata_i;
        REG_ERR_ANGLE:  err_score_q[KIND_ANGLE]  <= cfg_wdata_i;
        REG_PNT_ROUND:  point_q[KIND_ROUND]      <= cfg_wdata_i[POINT_W-1:0];
        REG_PNT_SQUARE: point_q[KIND_SQUARE]     <= cfg_wdata_i[POINT_W-1:0];
        REG_PNT_CURLY:  point_q[KIND_CURLY]      <= cfg_wdata_i[POINT_W-1:0];
        REG_PNT_ANGLE:  point_q[KIND_ANGLE]      <= cfg_wdata_i[POINT_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_RUN) && (!in_op_i || out_free);
  assign accept     = in_valid_i && in_ready_o;
  assign active     = !corrupted_q && !overflowed_q;
  assign char_acc   = accept && !in_op_i && active;
  assign eol_acc    = accept && in_op_i;
  assign cls        = bnc_classify(in_char_byte_i);
  assign top_match  = (level_q != '0) && (kinds[0] == cls.kind);
  assign do_corrupt = char_acc && cls.is_close && !top_match;
  assign total_sum  = {1'b0, total_q} + (TOTAL_W+1)'(err_score_q[cls.kind]);

  always_comb begin
    shift.push = char_acc && cls.is_open && (level_q != LVL_W'(STACK_DEPTH));
    shift.pop  = (char_acc && cls.is_close && top_match) ||
                 ((state_q == S_UNWIND) && (level_q != '0));
  end

  always_comb begin
    state_d      = state_q;
    level_d      = level_q;
    corrupted_d  = corrupted_q;
    overflowed_d = overflowed_q;
    latched_d    = latched_q;
    total_d      = total_q;
    out_load     = 1'b0;
    out_status   = STATUS_BALANCED;
    out_err      = '0;
    comp_clear   = 1'b0;

    if (shift.push) begin
      level_d = level_q + 1'b1;
    end else if (shift.pop) begin
      level_d = level_q - 1'b1;
    end

    if (char_acc && cls.is_open && (level_q == LVL_W'(STACK_DEPTH))) begin
      overflowed_d = 1'b1;
    end

    if (do_corrupt) begin
      corrupted_d = 1'b1;
      latched_d   = err_score_q[cls.kind];
      total_d     = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
    end

    if (eol_acc) begin
      corrupted_d  = 1'b0;
      overflowed_d = 1'b0;
      latched_d    = '0;
      if (overflowed_q) begin
        out_load   = 1'b1;
        out_status = STATUS_OVERFLOW;
        level_d    = '0;
      end else if (corrupted_q) begin
        out_load   = 1'b1;
        out_status = STATUS_CORRUPTED;
        out_err    = latched_q;
        level_d    = '0;
      end else if (level_q == '0) begin
        out_load   = 1'b1;
        out_status = STATUS_BALANCED;
      end else begin
        // keep the level: it counts the pops still to do
        comp_clear = 1'b1;
        state_d    = S_UNWIND;
      end
    end

    if ((state_q == S_UNWIND) && (level_q == '0) && out_free) begin
      out_load   = 1'b1;
      out_status = STATUS_INCOMPLETE;
      state_d    = S_RUN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_RUN;
      level_q      <= '0;
      corrupted_q  <= 1'b0;
      overflowed_q <= 1'b0;
      latched_q    <= '0;
      total_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      level_q      <= level_d;
      corrupted_q  <= corrupted_d;
      overflowed_q <= overflowed_d;
      latched_q    <= latched_d;
      total_q      <= total_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q     <= out_status;
      line_err_q   <= out_err;
      line_total_q <= total_q;
      comp_out_q   <= (out_status == STATUS_INCOMPLETE) ? comp : '0;
    end
  end

  // stack row: cell 0 is the top of the stack
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    bnc_kind_t up_kind, down_kind;
    if (i == 0) begin : g_top
      assign up_kind = cls.kind;
    end else begin : g_mid
      assign up_kind = kinds[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign down_kind = kinds[i];
    end else begin : g_inner
      assign down_kind = kinds[i+1];
    end
    bnc_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (shift),
      .up_kind_i   (up_kind),
      .down_kind_i (down_kind),
      .kind_o      (kinds[i])
    );
  end

  bnc_completion u_completion (
    .clk_i   (clk_i),
    .clear_i (comp_clear),
    .step_i  ((state_q == S_UNWIND) && (level_q != '0)),
    .digit_i (point_q[kinds[0]]),
    .score_o (comp)
  );

  assign out_valid_o             = out_valid_q;
  assign out_line_status_o       = status_q;
  assign out_line_error_score_o  = line_err_q;
  assign out_total_error_score_o = line_total_q;
  assign out_completion_score_o  = comp_out_q;

`ifndef NO_ASSERTIONS
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LVL_W'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_unwind_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UNWIND) |-> (!corrupted_q && !overflowed_q && !in_ready_o))
    else $error("unwind with dirty line state or open input");

  a_err_only_corrupt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_line_status_o != STATUS_CORRUPTED)) |->
      (out_line_error_score_o == '0))
    else $error("error score on non-corrupted line");

  a_comp_only_incomplete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_line_status_o != STATUS_INCOMPLETE)) |->
      (out_completion_score_o == '0))
    else $error("completion score on complete line");
`endif

endmodule
